/* design/assert_macros.svh */
// Assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property checked while out of reset
`define CLCD_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// property checked on every edge, reset included
`define CLCD_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define CLCD_ASSERT(name, clk, rstn, prop, msg)

`define CLCD_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

/* design/clcd_pkg.sv */
`default_nettype none

package clcd_pkg;

  // Command codes carried on the request's tuser
  typedef enum logic [2:0] {
    CMD_INIT   = 3'd0,
    CMD_CLEAR  = 3'd1,
    CMD_CURSOR = 3'd2,
    CMD_PRINT  = 3'd3,
    CMD_BLIGHT = 3'd4
  } cmd_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INIT,
    ST_BYTE,
    ST_BLIGHT
  } state_e;

  // Which generator supplies the current expander write
  typedef enum logic [1:0] {
    KIND_INIT,
    KIND_BYTE,
    KIND_BLIGHT
  } write_kind_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_DEV_ADDR = 2'd0,
    REG_COLS     = 2'd1,
    REG_ROWS     = 2'd2
  } reg_idx_e;

  localparam int unsigned MaxRows    = 4;
  localparam int unsigned InitWrites = 25;
  localparam int unsigned ByteWrites = 4;
  localparam int unsigned StepW      = $clog2(InitWrites);

  // Reset values of the configuration registers
  localparam logic [6:0] DevAddrRst = 7'd39;
  localparam logic [5:0] ColsRst    = 6'd16;
  localparam logic [2:0] RowsRst    = 3'd2;

  // Expander port bits
  localparam logic [7:0] BitRs = 8'h01;
  localparam logic [7:0] BitEn = 8'h04;
  localparam logic [7:0] BitBl = 8'h08;

  // LCD instruction bytes
  localparam logic [7:0] LcdClear    = 8'h01;
  localparam logic [7:0] LcdSetDdram = 8'h80;

  // Waits in microseconds
  localparam logic [14:0] DlyEnHigh = 15'd1;
  localparam logic [14:0] DlyEnLow  = 15'd50;
  localparam logic [14:0] DlyClear  = 15'd2050;
  localparam logic [14:0] DlyNone   = 15'd0;

  typedef struct packed {
    logic [7:0]  port_byte;
    logic [14:0] delay;
  } init_write_t;

  // Controller to datapath command group
  typedef struct packed {
    logic             load;
    cmd_e             op;
    logic             emit;
    write_kind_e      kind;
    logic [StepW-1:0] step;
    logic             last;
  } dp_cmd_t;

  // Datapath to controller status group
  typedef struct packed {
    logic emit_ok;
  } dp_sts_t;

  // DDRAM start address of each display row
  function automatic logic [7:0] row_base(input logic [1:0] row);
    logic [7:0] base;
    case (row)
      2'd0:    base = 8'h00;
      2'd1:    base = 8'h40;
      2'd2:    base = 8'h14;
      2'd3:    base = 8'h54;
      default: base = 8'h00;
    endcase
    return base;
  endfunction

  // Power-up sequence: reset write, three 0x3 pulses, one 0x2 pulse,
  // then function set, display on, clear and entry mode
  function automatic init_write_t init_write(input logic [StepW-1:0] step);
    init_write_t w;
    case (step)
      5'd0:    w = '{8'h00, 15'd20000};
      5'd1:    w = '{8'h34, DlyEnHigh};
      5'd2:    w = '{8'h30, 15'd5050};
      5'd3:    w = '{8'h34, DlyEnHigh};
      5'd4:    w = '{8'h30, 15'd5050};
      5'd5:    w = '{8'h34, DlyEnHigh};
      5'd6:    w = '{8'h30, 15'd200};
      5'd7:    w = '{8'h24, DlyEnHigh};
      5'd8:    w = '{8'h20, DlyEnLow};
      5'd9:    w = '{8'h24, DlyEnHigh};
      5'd10:   w = '{8'h20, DlyEnLow};
      5'd11:   w = '{8'h84, DlyEnHigh};
      5'd12:   w = '{8'h80, DlyEnLow};
      5'd13:   w = '{8'h04, DlyEnHigh};
      5'd14:   w = '{8'h00, DlyEnLow};
      5'd15:   w = '{8'hC4, DlyEnHigh};
      5'd16:   w = '{8'hC0, DlyEnLow};
      5'd17:   w = '{8'h04, DlyEnHigh};
      5'd18:   w = '{8'h00, DlyEnLow};
      5'd19:   w = '{8'h14, DlyEnHigh};
      5'd20:   w = '{8'h10, DlyClear};
      5'd21:   w = '{8'h04, DlyEnHigh};
      5'd22:   w = '{8'h00, DlyEnLow};
      5'd23:   w = '{8'h64, DlyEnHigh};
      5'd24:   w = '{8'h60, DlyEnLow};
      default: w = '{8'h00, DlyNone};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* design/clcd_ctrl.sv */
`default_nettype none

module clcd_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  output logic                   req_ready_o,
  input  wire logic [2:0]        req_cmd_i,
  input  wire clcd_pkg::dp_sts_t sts_i,
  output clcd_pkg::dp_cmd_t      cmd_o
);

  clcd_pkg::state_e              state_q, state_d;
  logic [clcd_pkg::StepW-1:0]    step_q, step_d;

  // State and step registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= clcd_pkg::ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    req_ready_o = 1'b0;
    cmd_o.load  = 1'b0;
    cmd_o.op    = clcd_pkg::cmd_e'(req_cmd_i);
    cmd_o.emit  = 1'b0;
    cmd_o.kind  = clcd_pkg::KIND_BYTE;
    cmd_o.step  = step_q;
    cmd_o.last  = 1'b0;
    case (state_q)
      clcd_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        step_d      = '0;
        if (req_valid_i) begin
          case (clcd_pkg::cmd_e'(req_cmd_i))
            clcd_pkg::CMD_INIT: begin
              cmd_o.load = 1'b1;
              state_d    = clcd_pkg::ST_INIT;
            end
            clcd_pkg::CMD_CLEAR, clcd_pkg::CMD_CURSOR, clcd_pkg::CMD_PRINT: begin
              cmd_o.load = 1'b1;
              state_d    = clcd_pkg::ST_BYTE;
            end
            clcd_pkg::CMD_BLIGHT: begin
              cmd_o.load = 1'b1;
              state_d    = clcd_pkg::ST_BLIGHT;
            end
            // unknown codes are dropped
            default: state_d = clcd_pkg::ST_IDLE;
          endcase
        end
      end
      clcd_pkg::ST_INIT: begin
        cmd_o.kind = clcd_pkg::KIND_INIT;
        cmd_o.last = (step_q == clcd_pkg::StepW'(clcd_pkg::InitWrites - 1));
        if (sts_i.emit_ok) begin
          cmd_o.emit = 1'b1;
          step_d     = step_q + clcd_pkg::StepW'(1);
          if (cmd_o.last) state_d = clcd_pkg::ST_IDLE;
        end
      end
      clcd_pkg::ST_BYTE: begin
        cmd_o.kind = clcd_pkg::KIND_BYTE;
        cmd_o.last = (step_q == clcd_pkg::StepW'(clcd_pkg::ByteWrites - 1));
        if (sts_i.emit_ok) begin
          cmd_o.emit = 1'b1;
          step_d     = step_q + clcd_pkg::StepW'(1);
          if (cmd_o.last) state_d = clcd_pkg::ST_IDLE;
        end
      end
      clcd_pkg::ST_BLIGHT: begin
        cmd_o.kind = clcd_pkg::KIND_BLIGHT;
        cmd_o.last = 1'b1;
        if (sts_i.emit_ok) begin
          cmd_o.emit = 1'b1;
          state_d    = clcd_pkg::ST_IDLE;
        end
      end
      default: state_d = clcd_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* design/clcd_dp.sv */
`default_nettype none

module clcd_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration writes
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [6:0]        cfg_data_i,
  // request payload
  input  wire logic [7:0]        col_position_i,
  input  wire logic [7:0]        row_position_i,
  input  wire logic [7:0]        char_code_i,
  input  wire logic              backlight_on_i,
  // controller link
  input  wire clcd_pkg::dp_cmd_t cmd_i,
  output clcd_pkg::dp_sts_t      sts_o,
  // result register
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [7:0]             out_byte_o,
  output logic [6:0]             out_addr_o,
  output logic [14:0]            out_delay_o,
  output logic                   out_last_o
);

  localparam logic [2:0] RowCap = 3'(clcd_pkg::MaxRows - 1);

  logic [6:0]  dev_addr_q;
  logic [5:0]  cols_q;
  logic [2:0]  rows_q;
  logic        bl_q;
  logic [7:0]  lcd_byte_q;
  logic        rs_q;
  logic        long_wait_q;

  logic        out_valid_q;
  logic [7:0]  out_byte_q, out_byte_d;
  logic [6:0]  out_addr_q;
  logic [14:0] out_delay_q, out_delay_d;
  logic        out_last_q;

  logic [2:0]  rmax_full;
  logic [1:0]  rmax;
  logic [5:0]  cmax;
  logic [1:0]  row_cl;
  logic [5:0]  col_cl;
  logic [7:0]  ddram_addr;

  logic [3:0]  nib;
  logic        en_phase;
  clcd_pkg::init_write_t iw;

  // Configuration registers and backlight state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= clcd_pkg::DevAddrRst;
      cols_q     <= clcd_pkg::ColsRst;
      rows_q     <= clcd_pkg::RowsRst;
      bl_q       <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        case (clcd_pkg::reg_idx_e'(cfg_index_i))
          clcd_pkg::REG_DEV_ADDR: dev_addr_q <= cfg_data_i;
          clcd_pkg::REG_COLS:     cols_q     <= cfg_data_i[5:0];
          clcd_pkg::REG_ROWS:     rows_q     <= cfg_data_i[2:0];
          default: ;
        endcase
      end
      if (cmd_i.load && cmd_i.op == clcd_pkg::CMD_BLIGHT) bl_q <= backlight_on_i;
    end
  end

  // Cursor clamp and DDRAM address
  always_comb begin
    rmax_full = (rows_q == 3'd0) ? 3'd0 : rows_q - 3'd1;
    if (rmax_full > RowCap) rmax_full = RowCap;
    rmax   = rmax_full[1:0];
    cmax   = (cols_q == 6'd0) ? 6'd0 : cols_q - 6'd1;
    row_cl = (row_position_i > {6'd0, rmax}) ? rmax : row_position_i[1:0];
    col_cl = (col_position_i > {2'd0, cmax}) ? cmax : col_position_i[5:0];
    ddram_addr = clcd_pkg::LcdSetDdram
               | ({2'd0, col_cl} + clcd_pkg::row_base(row_cl));
  end

  // LCD byte latched when a request is taken
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      case (cmd_i.op)
        clcd_pkg::CMD_CLEAR: begin
          lcd_byte_q  <= clcd_pkg::LcdClear;
          rs_q        <= 1'b0;
          long_wait_q <= 1'b1;
        end
        clcd_pkg::CMD_CURSOR: begin
          lcd_byte_q  <= ddram_addr;
          rs_q        <= 1'b0;
          long_wait_q <= 1'b0;
        end
        clcd_pkg::CMD_PRINT: begin
          lcd_byte_q  <= char_code_i;
          rs_q        <= 1'b1;
          long_wait_q <= 1'b0;
        end
        default: begin
          lcd_byte_q  <= '0;
          rs_q        <= 1'b0;
          long_wait_q <= 1'b0;
        end
      endcase
    end
  end

  // Expander write for the current step
  always_comb begin
    iw       = clcd_pkg::init_write(cmd_i.step);
    // high nibble first, EN high then EN low
    nib      = cmd_i.step[1] ? lcd_byte_q[3:0] : lcd_byte_q[7:4];
    en_phase = ~cmd_i.step[0];
    case (cmd_i.kind)
      clcd_pkg::KIND_INIT: begin
        out_byte_d  = iw.port_byte;
        out_delay_d = iw.delay;
      end
      clcd_pkg::KIND_BYTE: begin
        out_byte_d = {nib, 4'd0}
                   | (rs_q ? clcd_pkg::BitRs : 8'd0)
                   | (en_phase ? clcd_pkg::BitEn : 8'd0);
        if (en_phase)                          out_delay_d = clcd_pkg::DlyEnHigh;
        else if (cmd_i.step[1] && long_wait_q) out_delay_d = clcd_pkg::DlyClear;
        else                                   out_delay_d = clcd_pkg::DlyEnLow;
      end
      default: begin
        out_byte_d  = 8'd0;
        out_delay_d = clcd_pkg::DlyNone;
      end
    endcase
    if (bl_q) out_byte_d = out_byte_d | clcd_pkg::BitBl;
  end

  assign sts_o.emit_ok = ~out_valid_q | out_ready_i;

  // Result register: valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register: payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_byte_q  <= out_byte_d;
      out_addr_q  <= dev_addr_q;
      out_delay_q <= out_delay_d;
      out_last_q  <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_addr_o  = out_addr_q;
  assign out_delay_o = out_delay_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

/* design/char_lcd_i2c_expander_sequencer.sv */
`default_nettype none

`include "assert_macros.svh"

// Turns character LCD commands (init, clear, set cursor, print, backlight)
// into the byte writes for an I2C port expander wired to the LCD in 4-bit
// mode, each write tagged with its I2C address and the minimum wait in
// microseconds that must follow it; tlast marks a command's final write.
// A request is taken only while the sequencer is idle, and then writes
// leave one per clock through a single result register while the sink is
// ready: print, clear and set cursor give 4 writes, backlight 1 write and
// init 25 writes; unknown command codes are taken, dropped and produce
// nothing. The write step counter in the controller counts the init and
// byte writes. The caller still owes the 50 ms power-up wait before init.
module char_lcd_i2c_expander_sequencer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // command requests
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] col_position, [15:8] row_position, [23:16] char_code,
  // [24] backlight_on, [31:25] zero
  input  wire logic [31:0] s_axis_tdata,
  // [2:0] cmd
  input  wire logic [2:0]  s_axis_tuser,
  // expander writes
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] expander_byte, [14:8] target_address, [29:15] delay_after_us,
  // [31:30] zero
  output logic [31:0]      m_axis_tdata,
  output logic             m_axis_tlast,
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [6:0]  cfg_data_i
);

  clcd_pkg::dp_cmd_t dp_cmd;
  clcd_pkg::dp_sts_t dp_sts;

  logic [7:0]  out_byte;
  logic [6:0]  out_addr;
  logic [14:0] out_delay;

  assign cfg_ready_o = 1'b1;

  clcd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_cmd_i   (s_axis_tuser),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  clcd_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i & cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .col_position_i (s_axis_tdata[7:0]),
    .row_position_i (s_axis_tdata[15:8]),
    .char_code_i    (s_axis_tdata[23:16]),
    .backlight_on_i (s_axis_tdata[24]),
    .cmd_i          (dp_cmd),
    .sts_o          (dp_sts),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_byte_o     (out_byte),
    .out_addr_o     (out_addr),
    .out_delay_o    (out_delay),
    .out_last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_delay, out_addr, out_byte};

  // a write is only pushed when the result register can take it
  `CLCD_ASSERT(a_emit_has_room, clk_i, rst_ni, dp_cmd.emit |-> dp_sts.emit_ok, "write pushed into a full result register")
  // the payload is latched only on an accepted request
  `CLCD_ASSERT(a_load_on_accept, clk_i, rst_ni, dp_cmd.load |-> (s_axis_tvalid && s_axis_tready), "payload latched without a request")
  // no write is generated while the sequencer waits for a request
  `CLCD_ASSERT(a_idle_no_emit, clk_i, rst_ni, s_axis_tready |-> !dp_cmd.emit, "write generated while idle")
  // a pushed write shows up as valid on the next cycle
  `CLCD_ASSERT(a_emit_valid, clk_i, rst_ni, dp_cmd.emit |=> m_axis_tvalid, "pushed write not presented")

endmodule

`default_nettype wire

/* bench/char_lcd_i2c_expander_sequencer_test.sv */
`timescale 1ns / 100ps

module char_lcd_i2c_expander_sequencer_test;

  localparam int unsigned SettleCycles = 40;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned CycleLimit   = 300000;
  localparam int unsigned ShownFaults  = 10;

  // command codes the block ignores
  localparam logic [2:0] FirstUnusedOp = 3'd5;
  localparam logic [2:0] MidUnusedOp   = 3'd6;
  localparam logic [2:0] LastUnusedOp  = 3'd7;

  // LCD instruction bytes and nibbles used by the power-up sequence
  localparam logic [3:0] WakeNibble   = 4'h3;
  localparam logic [3:0] Mode4Nibble  = 4'h2;
  localparam logic [7:0] LcdFuncSet   = 8'h28;
  localparam logic [7:0] LcdDisplayOn = 8'h0C;
  localparam logic [7:0] LcdEntryMode = 8'h06;

  // extra settling time in microseconds
  localparam logic [14:0] PowerUpWait  = 15'd20000;
  localparam logic [14:0] WakeExtra    = 15'd5000;
  localparam logic [14:0] WakeExtraEnd = 15'd150;
  localparam logic [14:0] ClearExtra   = 15'd2000;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] ch;
    logic       bl;
  } lcd_req_t;

  typedef struct packed {
    logic [7:0]  port;
    logic [6:0]  addr;
    logic [14:0] wait_us;
    logic        last;
  } lcd_write_t;

  typedef struct packed {
    clcd_pkg::reg_idx_e idx;
    logic [6:0]         data;
  } cfg_write_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic [2:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i   = '0;
  logic [6:0]  cfg_data_i    = '0;

  // pending stimulus and writes still owed by the block
  lcd_req_t   req_q[$];
  cfg_write_t cfg_q[$];
  lcd_write_t writes_due[$];
  lcd_write_t batch[$];
  lcd_req_t   req_on_bus;
  cfg_write_t cfg_on_bus;

  // predictor copy of the registers and backlight state
  logic [6:0] dev_addr  = clcd_pkg::DevAddrRst;
  logic [5:0] col_count = clcd_pkg::ColsRst;
  logic [2:0] row_count = clcd_pkg::RowsRst;
  logic       bl_bit    = 1'b1;

  int unsigned send_idle_pct = 0;
  int unsigned rx_stall_pct  = 0;
  int unsigned hold_asks     = 0;
  int unsigned holds_served  = 0;
  int unsigned hold_left     = 0;
  int unsigned faults        = 0;
  int unsigned writes_seen   = 0;
  int unsigned reqs_taken    = 0;
  int unsigned settings_run  = 0;
  int unsigned cycles        = 0;
  lcd_write_t  got, want;

  char_lcd_i2c_expander_sequencer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------
  // Predictor: expander writes owed for one accepted request
  // ---------------------------------------------------------------
  task automatic put_write(input logic [7:0] b, input logic [14:0] d);
    lcd_write_t w;
    w.port    = b | (bl_bit ? clcd_pkg::BitBl : 8'h00);
    w.addr    = dev_addr;
    w.wait_us = d;
    w.last    = 1'b0;
    batch.push_back(w);
  endtask

  // EN high then EN low; extra goes on the falling write
  task automatic put_nibble(input logic [3:0] n, input logic rs, input logic [14:0] extra);
    logic [7:0] d;
    d = {n, 4'h0} | (rs ? clcd_pkg::BitRs : 8'h00);
    put_write(d | clcd_pkg::BitEn, clcd_pkg::DlyEnHigh);
    put_write(d & ~clcd_pkg::BitEn, clcd_pkg::DlyEnLow + extra);
  endtask

  task automatic put_byte(input logic [7:0] v, input logic rs, input logic [14:0] extra);
    put_nibble(v[7:4], rs, clcd_pkg::DlyNone);
    put_nibble(v[3:0], rs, extra);
  endtask

  task automatic predict_writes(input lcd_req_t r);
    logic [7:0] row_top, col_top, row_sel, col_sel, offset;
    batch.delete();
    case (r.op)
      clcd_pkg::CMD_INIT: begin
        put_write(8'h00, PowerUpWait);
        put_nibble(WakeNibble, 1'b0, WakeExtra);
        put_nibble(WakeNibble, 1'b0, WakeExtra);
        put_nibble(WakeNibble, 1'b0, WakeExtraEnd);
        put_nibble(Mode4Nibble, 1'b0, clcd_pkg::DlyNone);
        put_byte(LcdFuncSet, 1'b0, clcd_pkg::DlyNone);
        put_byte(LcdDisplayOn, 1'b0, clcd_pkg::DlyNone);
        put_byte(clcd_pkg::LcdClear, 1'b0, ClearExtra);
        put_byte(LcdEntryMode, 1'b0, clcd_pkg::DlyNone);
      end
      clcd_pkg::CMD_CLEAR: begin
        put_byte(clcd_pkg::LcdClear, 1'b0, ClearExtra);
      end
      clcd_pkg::CMD_CURSOR: begin
        // zero-sized registers clamp to 0; rows also capped at the row limit
        row_top = (row_count == 0) ? 8'd0 : 8'(row_count) - 8'd1;
        if (row_top > clcd_pkg::MaxRows - 1) row_top = 8'(clcd_pkg::MaxRows - 1);
        col_top = (col_count == 0) ? 8'd0 : 8'(col_count) - 8'd1;
        row_sel = (r.row > row_top) ? row_top : r.row;
        col_sel = (r.col > col_top) ? col_top : r.col;
        case (row_sel[1:0])
          2'd0:    offset = 8'h00;
          2'd1:    offset = 8'h40;
          2'd2:    offset = 8'h14;
          default: offset = 8'h54;
        endcase
        // sum wraps at 8 bits before the set-address bit goes in
        put_byte(clcd_pkg::LcdSetDdram | 8'(col_sel + offset), 1'b0, clcd_pkg::DlyNone);
      end
      clcd_pkg::CMD_PRINT: begin
        put_byte(r.ch, 1'b1, clcd_pkg::DlyNone);
      end
      clcd_pkg::CMD_BLIGHT: begin
        bl_bit = r.bl;
        put_write(8'h00, clcd_pkg::DlyNone);
      end
      default: ;
    endcase
    if (batch.size() != 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) writes_due.push_back(batch[i]);
  endtask

  task automatic report_fault(input string msg);
    faults++;
    if (faults <= ShownFaults) $display("mismatch: %s", msg);
  endtask

  // ---------------------------------------------------------------
  // Driver: command requests and register writes
  // ---------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_writes(req_on_bus);
        reqs_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_on_bus = req_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= req_on_bus.op;
          s_axis_tdata  <= {7'd0, req_on_bus.bl, req_on_bus.ch, req_on_bus.row, req_on_bus.col};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end

      // registers only change while nothing is in flight
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_on_bus.idx)
          clcd_pkg::REG_DEV_ADDR: dev_addr  = cfg_on_bus.data;
          clcd_pkg::REG_COLS:     col_count = cfg_on_bus.data[5:0];
          clcd_pkg::REG_ROWS:     row_count = cfg_on_bus.data[2:0];
          default: ;
        endcase
      end
      if (!cfg_valid_i || cfg_ready_o) begin
        if (cfg_q.size() != 0) begin
          cfg_on_bus = cfg_q.pop_front();
          cfg_valid_i <= 1'b1;
          cfg_index_i <= cfg_on_bus.idx;
          cfg_data_i  <= cfg_on_bus.data;
        end else begin
          cfg_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Monitor: check each write, drive the sink's ready
  // ---------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.port    = m_axis_tdata[7:0];
        got.addr    = m_axis_tdata[14:8];
        got.wait_us = m_axis_tdata[29:15];
        got.last    = m_axis_tlast;
        if (writes_due.size() == 0) begin
          report_fault($sformatf("write %0d not expected: byte %h addr %h wait %0d last %b",
                                 writes_seen, got.port, got.addr, got.wait_us, got.last));
        end else begin
          want = writes_due.pop_front();
          if (got.port != want.port)
            report_fault($sformatf("write %0d expander_byte: expected %h, got %h",
                                   writes_seen, want.port, got.port));
          if (got.addr != want.addr)
            report_fault($sformatf("write %0d target_address: expected %h, got %h",
                                   writes_seen, want.addr, got.addr));
          if (got.wait_us != want.wait_us)
            report_fault($sformatf("write %0d delay_after_us: expected %0d, got %0d",
                                   writes_seen, want.wait_us, got.wait_us));
          if (got.last != want.last)
            report_fault($sformatf("write %0d last: expected %b, got %b",
                                   writes_seen, want.last, got.last));
        end
        writes_seen++;
      end

      // a long hold-off on request, otherwise random stalls
      if (holds_served != hold_asks) begin
        holds_served = hold_asks;
        hold_left    = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d writes still owed", cycles, writes_due.size());
      $display("** char_lcd_i2c_expander_sequencer: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------
  task automatic queue_req(input logic [2:0] op, input logic [7:0] col, input logic [7:0] row,
                           input logic [7:0] ch, input logic bl);
    lcd_req_t r;
    r = '{op: op, col: col, row: row, ch: ch, bl: bl};
    req_q.push_back(r);
  endtask

  // mostly prints and cursor moves; unused codes do not count
  task automatic queue_random(input int unsigned n);
    int unsigned done, pick;
    logic [2:0]  op;
    logic [7:0]  col, row;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(99);
      if (pick < 6)       op = clcd_pkg::CMD_INIT;
      else if (pick < 16) op = clcd_pkg::CMD_CLEAR;
      else if (pick < 45) op = clcd_pkg::CMD_PRINT;
      else if (pick < 75) op = clcd_pkg::CMD_CURSOR;
      else if (pick < 88) op = clcd_pkg::CMD_BLIGHT;
      else                op = 3'($urandom_range(LastUnusedOp, FirstUnusedOp));
      col = $urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(45));
      row = $urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(5));
      queue_req(op, col, row, 8'($urandom_range(255)), 1'($urandom_range(1)));
      if (op < FirstUnusedOp) done++;
    end
  endtask

  task automatic wait_quiet();
    while (req_q.size() != 0 || s_axis_tvalid || writes_due.size() != 0) @(negedge clk_i);
    // an ignored code may still be inside the block
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic run_setting(input logic [6:0] addr, input logic [6:0] cols,
                             input logic [6:0] rows, input int unsigned tx_idle,
                             input int unsigned rx_idle, input int unsigned n);
    cfg_write_t c;
    c = '{idx: clcd_pkg::REG_DEV_ADDR, data: addr};
    cfg_q.push_back(c);
    c = '{idx: clcd_pkg::REG_COLS, data: cols};
    cfg_q.push_back(c);
    c = '{idx: clcd_pkg::REG_ROWS, data: rows};
    cfg_q.push_back(c);
    while (cfg_q.size() != 0 || cfg_valid_i) @(negedge clk_i);
    send_idle_pct = tx_idle;
    rx_stall_pct  = rx_idle;
    // sweep every row with an oversized column
    for (int i = 0; i < 5; i++) queue_req(clcd_pkg::CMD_CURSOR, 8'hFF, 8'(i), 8'h00, 1'b0);
    queue_random(n);
    wait_quiet();
    settings_run++;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part at the reset register values
    queue_req(clcd_pkg::CMD_INIT,   8'h00, 8'h00, 8'h00, 1'b0);
    queue_req(clcd_pkg::CMD_PRINT,  8'h00, 8'h00, 8'h00, 1'b0);
    queue_req(clcd_pkg::CMD_PRINT,  8'hFF, 8'hFF, 8'hFF, 1'b1);
    queue_req(clcd_pkg::CMD_PRINT,  8'h00, 8'h00, 8'h5A, 1'b1);
    queue_req(clcd_pkg::CMD_CLEAR,  8'h00, 8'h00, 8'h00, 1'b0);
    queue_req(clcd_pkg::CMD_CURSOR, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_req(clcd_pkg::CMD_CURSOR, 8'd15, 8'd1,  8'h00, 1'b0);
    queue_req(clcd_pkg::CMD_CURSOR, 8'd16, 8'd2,  8'h00, 1'b0);
    queue_req(clcd_pkg::CMD_CURSOR, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    queue_req(clcd_pkg::CMD_BLIGHT, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_req(clcd_pkg::CMD_PRINT,  8'h00, 8'h00, 8'hA5, 1'b0);
    queue_req(clcd_pkg::CMD_CURSOR, 8'd7,  8'd0,  8'h00, 1'b0);
    queue_req(clcd_pkg::CMD_INIT,   8'hFF, 8'hFF, 8'hFF, 1'b1);
    queue_req(clcd_pkg::CMD_BLIGHT, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    queue_req(FirstUnusedOp, 8'h12, 8'h34, 8'h56, 1'b1);
    queue_req(MidUnusedOp, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    queue_req(LastUnusedOp, 8'h00, 8'h00, 8'h00, 1'b1);
    queue_req(clcd_pkg::CMD_PRINT,  8'h00, 8'h00, 8'h80, 1'b0);
    queue_req(clcd_pkg::CMD_CLEAR,  8'hFF, 8'hFF, 8'hFF, 1'b1);
    wait_quiet();

    // register settings, extremes first, idling varied per setting
    run_setting(7'd0,   7'd1,   7'd1,   0,  0,  16);
    run_setting(7'd127, 7'd40,  7'd4,   67, 0,  16);
    run_setting(7'h55,  7'h7F,  7'h7F,  0,  67, 16);
    run_setting(7'h2A,  7'd0,   7'd0,   33, 33, 16);
    run_setting(7'($urandom_range(127)), 7'($urandom_range(40, 1)),
                7'($urandom_range(4, 1)), 0, 0, 16);
    run_setting(clcd_pkg::DevAddrRst, 7'd20, 7'd4, 67, 0, 16);
    run_setting(7'h31, 7'd16, 7'h7C, 33, 33, 16);

    // sink held off while the source keeps offering requests
    send_idle_pct = 0;
    rx_stall_pct  = 0;
    queue_random(30);
    hold_asks++;
    wait_quiet();

    $display("%0d commands taken, %0d expander writes checked, %0d register settings",
             reqs_taken, writes_seen, settings_run + 1);
    $display("covered power-up, clear, cursor clamping, print, backlight and ignored codes");
    if (faults == 0) begin
      $display("** char_lcd_i2c_expander_sequencer: PASSED **");
    end else begin
      $display("%0d mismatches", faults);
      $display("** char_lcd_i2c_expander_sequencer: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/clcd_pkg.sv
design/clcd_ctrl.sv
design/clcd_dp.sv
design/char_lcd_i2c_expander_sequencer.sv
bench/char_lcd_i2c_expander_sequencer_test.sv
